// ===== rtl/vvv_pkg.sv =====
package vvv_pkg;

  // Transformed coordinate width: products are 64 bits, four of them summed
  localparam int SUM_W = 67;

  // Split of |z| for the bound multiply
  localparam int CH_W = 23;
  localparam int CH_N = 3;
  localparam int AZ_W = CH_W * CH_N;

  // Bound magnitude width and derived product widths
  localparam int BND_W = 32;
  localparam int PP_W  = CH_W + BND_W;
  localparam int T_W   = AZ_W + BND_W;

  // Configuration port
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_ROW_X01 = 3'd0,
    REG_ROW_X23 = 3'd1,
    REG_ROW_Y01 = 3'd2,
    REG_ROW_Y23 = 3'd3,
    REG_ROW_Z01 = 3'd4,
    REG_ROW_Z23 = 3'd5,
    REG_MARGIN  = 3'd6
  } reg_idx_t;

endpackage

// ===== rtl/vvv_row.sv =====
module vvv_row #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [63:0]                        c01,
  input  logic [63:0]                        c23,
  input  logic signed [31:0]                 vx,
  input  logic signed [31:0]                 vy,
  input  logic signed [31:0]                 vz,
  output logic signed [vvv_pkg::SUM_W-1:0]   sum
);
  import vvv_pkg::*;

  logic signed [63:0] p0;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [63:0] p3;

  // Form the four terms of the row; the last column meets a constant one
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= $signed(c01[31:0])  * vx;
      p1 <= $signed(c01[63:32]) * vy;
      p2 <= $signed(c23[31:0])  * vz;
      p3 <= 64'($signed(c23[63:32])) <<< FRAC_BITS;
    end
  end

  // Add the terms at full width
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + SUM_W'(p3);
    end
  end

endmodule

// ===== rtl/vertex_view_visibility_test.sv =====
// Throughput: one vertex per cycle; the pipeline advances as a whole
// whenever the output register is empty or being taken.
// Reset: synchronous; clears all stage valid bits, the output valid and
// every configuration register to zero.
module vertex_view_visibility_test #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vvv_pkg::ADDR_W-1:0]    paddr,
  input  logic [vvv_pkg::DATA_W-1:0]    pwdata,
  output logic [vvv_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          vertex_valid,
  output logic                          vertex_ready,
  input  logic signed [31:0]            vertex_x,
  input  logic signed [31:0]            vertex_y,
  input  logic signed [31:0]            vertex_z,
  output logic                          visible_valid,
  input  logic                          visible_ready,
  output logic                          visible
);
  import vvv_pkg::*;

  localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
  localparam longint NEAR_Q = (ONE_Q + 5) / 10;
  localparam logic signed [SUM_W-1:0] NEAR_LIM =
    -(SUM_W'(NEAR_Q) <<< FRAC_BITS);
  localparam logic signed [BND_W:0] ONE_B = (BND_W+1)'(ONE_Q);

  // Configuration registers
  logic [63:0] row_x01, row_x23, row_y01, row_y23, row_z01, row_z23;
  logic [31:0] margin;
  reg_idx_t    widx;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[5:3]);
  assign ridx   = reg_idx_t'(paddr[5:3]);

  // Take register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x01 <= '0;
      row_x23 <= '0;
      row_y01 <= '0;
      row_y23 <= '0;
      row_z01 <= '0;
      row_z23 <= '0;
      margin  <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_ROW_X01: row_x01 <= pwdata;
        REG_ROW_X23: row_x23 <= pwdata;
        REG_ROW_Y01: row_y01 <= pwdata;
        REG_ROW_Y23: row_y23 <= pwdata;
        REG_ROW_Z01: row_z01 <= pwdata;
        REG_ROW_Z23: row_z23 <= pwdata;
        REG_MARGIN:  margin  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Return register contents
  always_comb begin
    case (ridx)
      REG_ROW_X01: prdata = row_x01;
      REG_ROW_X23: prdata = row_x23;
      REG_ROW_Y01: prdata = row_y01;
      REG_ROW_Y23: prdata = row_y23;
      REG_ROW_Z01: prdata = row_z01;
      REG_ROW_Z23: prdata = row_z23;
      REG_MARGIN:  prdata = {32'd0, margin};
      default:     prdata = '0;
    endcase
  end

  // Whole pipeline advances together
  logic       en;
  logic [4:0] vld;

  assign en           = !visible_valid || visible_ready;
  assign vertex_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      visible_valid <= 1'b0;
    end else if (en) begin
      vld           <= {vld[3:0], vertex_valid};
      visible_valid <= vld[4];
    end
  end

  // Stages 1 and 2: row dot products
  logic signed [SUM_W-1:0] x_s2, y_s2, z_s2;

  vvv_row #(.FRAC_BITS(FRAC_BITS)) u_row_x (
    .clk(clk), .en(en), .c01(row_x01), .c23(row_x23),
    .vx(vertex_x), .vy(vertex_y), .vz(vertex_z), .sum(x_s2)
  );
  vvv_row #(.FRAC_BITS(FRAC_BITS)) u_row_y (
    .clk(clk), .en(en), .c01(row_y01), .c23(row_y23),
    .vx(vertex_x), .vy(vertex_y), .vz(vertex_z), .sum(y_s2)
  );
  vvv_row #(.FRAC_BITS(FRAC_BITS)) u_row_z (
    .clk(clk), .en(en), .c01(row_z01), .c23(row_z23),
    .vx(vertex_x), .vy(vertex_y), .vz(vertex_z), .sum(z_s2)
  );

  // Stage 3: magnitudes and depth checks
  logic [SUM_W-1:0] ax_s3, ay_s3, az_s3;
  logic             zok_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_s3  <= x_s2[SUM_W-1] ? SUM_W'(-x_s2) : SUM_W'(x_s2);
      ay_s3  <= y_s2[SUM_W-1] ? SUM_W'(-y_s2) : SUM_W'(y_s2);
      az_s3  <= z_s2[SUM_W-1] ? SUM_W'(-z_s2) : SUM_W'(z_s2);
      zok_s3 <= (z_s2 != '0) && (z_s2 >= NEAR_LIM);
    end
  end

  // Bound 1 + margin; an empty window when it is not positive
  logic signed [BND_W:0] bound;
  logic                  bound_pos;
  logic [AZ_W-1:0]       az_pad;

  assign bound     = ONE_B + $signed({margin[31], margin});
  assign bound_pos = !bound[BND_W] && (bound != '0);
  assign az_pad    = AZ_W'(az_s3);

  // Stage 4: partial products of |z| by the bound
  logic [PP_W-1:0]  pp_s4 [CH_N];
  logic [SUM_W-1:0] ax_s4, ay_s4;
  logic             ok_s4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < CH_N; k++) begin
        pp_s4[k] <= PP_W'(az_pad[k*CH_W +: CH_W]) * PP_W'(bound[BND_W-1:0]);
      end
      ax_s4 <= ax_s3;
      ay_s4 <= ay_s3;
      ok_s4 <= zok_s3 && bound_pos;
    end
  end

  // Stage 5: gather partial products into the window edge
  logic [T_W-1:0]   t_s5;
  logic [SUM_W-1:0] ax_s5, ay_s5;
  logic             ok_s5;

  always_ff @(posedge clk) begin
    if (en) begin
      t_s5  <= T_W'(pp_s4[0]) + (T_W'(pp_s4[1]) << CH_W)
             + (T_W'(pp_s4[2]) << (2*CH_W));
      ax_s5 <= ax_s4;
      ay_s5 <= ay_s4;
      ok_s5 <= ok_s4;
    end
  end

  // Stage 6: strict window compare into the output register
  logic [T_W-1:0] xs, ys;

  assign xs = T_W'(ax_s5) << FRAC_BITS;
  assign ys = T_W'(ay_s5) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      visible <= ok_s5 && (xs < t_s5) && (ys < t_s5);
    end
  end

  // Hold every stage while the output word waits
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  // An accepted word enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex_ready |=> vld[0])
    else $error("accepted vertex word did not enter the pipeline");

  // The last stage reaches the output on an advance
  a_exit: assert property (@(posedge clk) disable iff (rst)
    en && vld[4] |=> visible_valid)
    else $error("result word lost at the output register");

endmodule
